### src/time_of_day_clock_with_alarms_macros.svh
// Assertion macros used by the checker of the time-of-day clock.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef TIME_OF_DAY_CLOCK_WITH_ALARMS_MACROS_SVH
`define TIME_OF_DAY_CLOCK_WITH_ALARMS_MACROS_SVH

// Same-cycle implication.
`define TDCA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tdca: same-cycle check failed");

// Next-cycle implication.
`define TDCA_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tdca: next-cycle check failed");

`endif

### src/tdca_pkg.sv
// Package of the time-of-day clock with alarms: item types, mode codes and time limits.
// Used by the top level and by its checker; depends on nothing.
package tdca_pkg;

	localparam logic [2:0] MODE_TICK      = 3'd0;
	localparam logic [2:0] MODE_QUERY     = 3'd1;
	localparam logic [2:0] MODE_CLEAR     = 3'd2;
	localparam logic [2:0] MODE_TRIGGER   = 3'd3;
	localparam logic [2:0] MODE_SET_ALARM = 3'd4;
	localparam logic [2:0] MODE_SET_CLOCK = 3'd5;

	localparam logic [5:0] LAST_SECOND = 6'd59;
	localparam logic [5:0] LAST_MINUTE = 6'd59;
	localparam logic [4:0] LAST_HOUR   = 5'd23;
	localparam logic [6:0] IDLE_HOUR   = 7'd99;

	// Width of the flag masks shown in a result.
	localparam int MASK_W = 8;

	typedef struct packed {
		logic [2:0] mode;
		logic [2:0] alarm_index;
		logic [6:0] hour_value;
		logic [5:0] minute_value;
		logic [5:0] second_value;
	} in_item_t;

	typedef struct packed {
		logic [4:0]        hour_now;
		logic [5:0]        minute_now;
		logic [5:0]        second_now;
		logic              alarm_active;
		logic [MASK_W-1:0] active_mask;
		logic [MASK_W-1:0] matched_mask;
	} out_item_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} tod_t;

	typedef struct packed {
		logic [6:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} alarm_time_t;

endpackage

### src/time_of_day_clock_with_alarms.sv
// Top level of the 24-hour time-of-day clock with a table of alarms.
// Depends on tdca_pkg for the item types, mode codes and time limits.
//
//   channel   direction  handshake            payload
//   in        into       in_valid/in_ready    in_data  (tdca_pkg::in_item_t)
//   out       out of     out_valid/out_ready  out_data (tdca_pkg::out_item_t)
//
// Every input transfer yields exactly one result, shown on the output the next cycle.
// The state update and the result are computed in the cycle of the input transfer,
// so one item per cycle enters unless the output stalls; one register sets the latency.
// Reset clears the clock to 00:00:00, all flags to zero and all alarms to 99:00:00.
// While a result waits for out_ready, in_ready is low; it rises in the cycle the
// waiting result is taken.
module time_of_day_clock_with_alarms #(
	parameter int ALARM_COUNT = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tdca_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tdca_pkg::out_item_t out_data
);
	import tdca_pkg::*;

	// Architectural state: the clock, the alarm table and the sticky flags.
	tod_t                   time_q;
	alarm_time_t            alarm_q [ALARM_COUNT];
	logic [ALARM_COUNT-1:0] flags_q;

	// Result register.
	logic      out_valid_q;
	out_item_t out_data_q;

	logic                   accept;
	logic [ALARM_COUNT-1:0] sel;
	logic [ALARM_COUNT-1:0] match;
	logic [ALARM_COUNT-1:0] alarm_we;
	logic [ALARM_COUNT-1:0] flags_d;
	logic [ALARM_COUNT-1:0] matched;
	logic [MASK_W-1:0]      active_mask;
	logic [MASK_W-1:0]      matched_mask;
	tod_t                   tick_time;
	tod_t                   set_time;
	tod_t                   time_d;
	out_item_t              result;

	// The output register empties when its result is taken, so a new item can
	// enter in the same cycle.
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// One-hot select of the addressed alarm. An index beyond the table selects
	// nothing, which makes query, clear, trigger and set-alarm harmless.
	always_comb begin
		for (int i = 0; i < ALARM_COUNT; i++) begin
			sel[i] = (int'(in_data.alarm_index) == i);
		end
	end

	// One-second advance with the usual wrap of seconds, minutes and hours.
	always_comb begin
		tick_time = time_q;
		if (time_q.second >= LAST_SECOND) begin
			tick_time.second = '0;
			if (time_q.minute >= LAST_MINUTE) begin
				tick_time.minute = '0;
				if (time_q.hour >= LAST_HOUR) begin
					tick_time.hour = '0;
				end else begin
					tick_time.hour = time_q.hour + 5'd1;
				end
			end else begin
				tick_time.minute = time_q.minute + 6'd1;
			end
		end else begin
			tick_time.second = time_q.second + 6'd1;
		end
	end

	// Parallel comparators against the advanced time. The alarm hour is seven
	// bits wide, so an alarm parked at hour 99 can never match.
	always_comb begin
		for (int i = 0; i < ALARM_COUNT; i++) begin
			match[i] = (alarm_q[i].hour == {2'b00, tick_time.hour})
				&& (alarm_q[i].minute == tick_time.minute)
				&& (alarm_q[i].second == tick_time.second);
		end
	end

	// Setting the clock clamps each field to its largest legal value.
	always_comb begin
		set_time.hour   = (in_data.hour_value > {2'b00, LAST_HOUR}) ?
			LAST_HOUR : in_data.hour_value[4:0];
		set_time.minute = (in_data.minute_value > LAST_MINUTE) ?
			LAST_MINUTE : in_data.minute_value;
		set_time.second = (in_data.second_value > LAST_SECOND) ?
			LAST_SECOND : in_data.second_value;
	end

	// Next-state selection by mode. Unused mode codes leave the state alone.
	always_comb begin
		time_d   = time_q;
		flags_d  = flags_q;
		matched  = '0;
		alarm_we = '0;
		unique case (in_data.mode)
			MODE_TICK: begin
				time_d  = tick_time;
				matched = match;
				flags_d = flags_q | match;
			end
			MODE_QUERY: begin
				flags_d = flags_q;
			end
			MODE_CLEAR: begin
				flags_d = flags_q & ~sel;
			end
			MODE_TRIGGER: begin
				flags_d = flags_q | sel;
			end
			MODE_SET_ALARM: begin
				alarm_we = sel;
			end
			MODE_SET_CLOCK: begin
				time_d = set_time;
			end
			default: begin
				time_d = time_q;
			end
		endcase
	end

	// The masks in a result show the low alarms only; with fewer alarms than
	// mask bits the upper bits read as zero.
	for (genvar i = 0; i < MASK_W; i++) begin : g_mask
		if (i < ALARM_COUNT) begin : g_used
			assign active_mask[i]  = flags_d[i];
			assign matched_mask[i] = matched[i];
		end else begin : g_unused
			assign active_mask[i]  = 1'b0;
			assign matched_mask[i] = 1'b0;
		end
	end

	always_comb begin
		result.hour_now     = time_d.hour;
		result.minute_now   = time_d.minute;
		result.second_now   = time_d.second;
		result.alarm_active = |(flags_d & sel);
		result.active_mask  = active_mask;
		result.matched_mask = matched_mask;
	end

	// State registers change only on an input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q  <= '0;
			flags_q <= '0;
			for (int i = 0; i < ALARM_COUNT; i++) begin
				alarm_q[i] <= '{hour: IDLE_HOUR, minute: 6'd0, second: 6'd0};
			end
		end else if (accept) begin
			time_q  <= time_d;
			flags_q <= flags_d;
			for (int i = 0; i < ALARM_COUNT; i++) begin
				if (alarm_we[i]) begin
					alarm_q[i] <= '{hour: in_data.hour_value,
						minute: in_data.minute_value,
						second: in_data.second_value};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= result;
		end
	end

endmodule

### src/tdca_checker.sv
// Port-level checker for the time-of-day clock with alarms, bound to the top level.
// Depends on tdca_pkg and on the assertion macros in time_of_day_clock_with_alarms_macros.svh.
`include "time_of_day_clock_with_alarms_macros.svh"

module tdca_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input tdca_pkg::out_item_t out_data
);
	import tdca_pkg::*;

	// A result that is not taken stays on the port unchanged.
	`TDCA_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(out_data))

	// The shown time is always a legal time of day.
	`TDCA_ASSERT_IMP(a_time_range, out_valid,
		(out_data.hour_now <= LAST_HOUR) && (out_data.minute_now <= LAST_MINUTE)
		&& (out_data.second_now <= LAST_SECOND))

	// Alarms that matched on this tick are active afterwards.
	`TDCA_ASSERT_IMP(a_match_sets_flag, out_valid,
		(out_data.matched_mask & ~out_data.active_mask) == '0)

	// With no result waiting the block always takes an item.
	`TDCA_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready)

	// An input transfer always produces a result in the next cycle.
	`TDCA_ASSERT_NXT(a_one_result, in_valid && in_ready, out_valid)

endmodule

bind time_of_day_clock_with_alarms tdca_checker u_tdca_checker (.*);
